@@ hdl/mipmap_box_downsampler_core_macros.svh @@
// Assertion macros for the mipmap box downsampler.
`ifndef MIPMAP_BOX_DOWNSAMPLER_CORE_MACROS_SVH
`define MIPMAP_BOX_DOWNSAMPLER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every clk edge outside reset.
`define MBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on every clk edge outside reset.
`define MBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MBD_ASSERT_NOW(lbl, ante, cons, msg)
`define MBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/mbd_pkg.sv @@
// Package: types and constants of the mipmap box downsampler.
`default_nettype none

package mbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int SIZE_W     = 13;                  // size register width
  localparam int COL_W      = $clog2(MAX_WIDTH);   // column counter width
  localparam int ROW_W      = $clog2(MAX_HEIGHT);  // row counter width
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int X_W        = $clog2(LINE_DEPTH);
  localparam int CHAN_W     = 8;
  localparam int PAIR_W     = CHAN_W + 1;
  localparam int NCHAN      = 4;
  localparam int ADDR_W     = 3;

  // Register indexes (paddr bit 2)
  localparam logic REG_SOURCE_WIDTH  = 1'b0;
  localparam logic REG_SOURCE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } src_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              last_of_image;
  } mip_pixel_t;

  typedef logic [NCHAN-1:0][CHAN_W-1:0] chan4_t;
  typedef logic [NCHAN-1:0][PAIR_W-1:0] pair4_t;

endpackage

`default_nettype wire

@@ hdl/mipmap_box_downsampler_core.sv @@
// 2x2 box-filter mipmap downsampler: raster RGBA in, half-size RGBA out.
//
// Usage
//   src channel: one RGBA source pixel per item, raster order, accepted at a
//   clk edge with src_valid high and src_stall low.
//   mip channel: one averaged pixel per 2x2 source block, last_of_image set
//   on the final pixel of the reduced image; taken when mip_stall is low.
//   APB port: source_width at byte address 0, source_height at 4 (1..4096,
//   taken from pwdata[12:0]; 0 reads as 1, larger values saturate). Any
//   write restarts the frame. Write only while idle.
// Throughput: one source item per cycle while src_stall is low, also while the
//   mip side holds a finished pixel until the sum stage fills. The line store is
//   one read and one write port; an entry's odd-row read follows its write.
// Path: a pixel that completes a block goes into the line store read and pair
//   register at its accept edge, then into the output register when mip has room.
// Stall: the mip side stalling holds the output register; the next block
//   waits in the sum stage, and only when both are full does src_stall rise.
// Reset: counters and held pixel clear, sizes go to 1x1, pipeline empties.
//   The line store is not cleared; every summed read follows a write in the frame.
`default_nettype none

`include "mipmap_box_downsampler_core_macros.svh"

module mipmap_box_downsampler_core
  import mbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // source pixels
  input  wire logic              src_valid,
  output logic                   src_stall,
  input  wire src_pixel_t        src,
  // reduced pixels
  output logic                   mip_valid,
  input  wire logic              mip_stall,
  output mip_pixel_t             mip,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Size registers
  logic [SIZE_W-1:0] source_width;
  logic [SIZE_W-1:0] source_height;

  // Position of the next source pixel and the even-column pixel of the pair
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  chan4_t            held_pixel;

  // Line store of even-row pair sums
  logic [NCHAN*PAIR_W-1:0] line_mem [LINE_DEPTH];
  pair4_t                  line_rd;

  // Sum stage
  logic   s1_valid;
  pair4_t s1_pair;
  logic   s1_h1;
  logic   s1_last;

  logic cfg_we;
  logic accept;
  logic s1_move;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SOURCE_WIDTH:  prdata = 32'(source_width);
      REG_SOURCE_HEIGHT: prdata = 32'(source_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_W'(1);
      source_height <= SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_SOURCE_WIDTH:
          source_width  <= clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_WIDTH));
        REG_SOURCE_HEIGHT:
          source_height <= clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: pair sums, line store access, counters
  // ---------------------------------------------------------------------
  logic                w1, h1;
  logic                last_col, last_row;
  logic [SIZE_W-2:0]   half_w, half_h, out_w, out_h;
  logic [X_W-1:0]      x;
  logic [ROW_W-2:0]    y;
  logic                have_pair, line_we, emit, blk_last;
  chan4_t              pix;
  pair4_t              pair;

  assign src_stall = s1_valid && mip_valid && mip_stall;
  assign accept    = src_valid && !src_stall;

  assign w1 = (source_width == SIZE_W'(1));
  assign h1 = (source_height == SIZE_W'(1));

  assign last_col = (SIZE_W'(col_count) == source_width - SIZE_W'(1));
  assign last_row = (SIZE_W'(row_count) == source_height - SIZE_W'(1));

  assign half_w = source_width[SIZE_W-1:1];
  assign half_h = source_height[SIZE_W-1:1];
  assign out_w  = (half_w == '0) ? (SIZE_W-1)'(1) : half_w;
  assign out_h  = (half_h == '0) ? (SIZE_W-1)'(1) : half_h;

  assign x = col_count[COL_W-1:1];
  assign y = row_count[ROW_W-1:1];

  assign pix = {src.alpha, src.blue, src.green, src.red};

  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      if (w1) pair[k] = {pix[k], 1'b0};
      else    pair[k] = {1'b0, held_pixel[k]} + {1'b0, pix[k]};
    end
  end

  // Odd columns (or every column of a one-wide image) close a pair; even
  // rows park it in the line store, odd rows (or a one-high image) emit.
  assign have_pair = w1 || col_count[0];
  assign line_we   = have_pair && !h1 && !row_count[0] &&
                     ((SIZE_W-1)'(y) < out_h);
  assign emit      = have_pair && (h1 || row_count[0]);
  assign blk_last  = ((SIZE_W-1)'(x) == out_w - (SIZE_W-1)'(1)) &&
                     ((SIZE_W-1)'(y) == out_h - (SIZE_W-1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      held_pixel <= '0;
    end else if (cfg_we) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (!w1 && !col_count[0]) held_pixel <= pix;
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // A write to entry x and the odd-row read of x never share an edge, so
  // the registered read always sees the stored pair sum.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (line_we) line_mem[x] <= pair;
      line_rd <= line_mem[x];
    end
  end

  // ---------------------------------------------------------------------
  // Sum stage and output register
  // ---------------------------------------------------------------------
  assign s1_move = s1_valid && (!mip_valid || !mip_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && emit) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_pair <= pair;
      s1_h1   <= h1;
      s1_last <= blk_last;
    end
  end

  chan4_t avg;
  always_comb begin
    logic [PAIR_W:0] sum;
    for (int k = 0; k < NCHAN; k++) begin
      if (s1_h1) sum = {s1_pair[k], 1'b0};
      else       sum = {1'b0, line_rd[k]} + {1'b0, s1_pair[k]};
      avg[k] = sum[PAIR_W:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mip_valid <= 1'b0;
    end else if (s1_move) begin
      mip_valid <= 1'b1;
    end else if (!mip_stall) begin
      mip_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      mip.out_red       <= avg[0];
      mip.out_green     <= avg[1];
      mip.out_blue      <= avg[2];
      mip.out_alpha     <= avg[3];
      mip.last_of_image <= s1_last;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `MBD_ASSERT_NOW(a_stall_only_when_full, src_stall, s1_valid && mip_valid,
                  "src stalled while the pipeline has room")
  `MBD_ASSERT_NOW(a_col_in_range, 1'b1, SIZE_W'(col_count) < source_width,
                  "column counter beyond source width")
  `MBD_ASSERT_NEXT(a_cfg_restarts, cfg_we, col_count == '0 && row_count == '0,
                   "config write did not restart the frame")
  `MBD_ASSERT_NEXT(a_sum_stage_holds, s1_valid && mip_valid && mip_stall,
                   s1_valid && $stable(s1_pair) && (s1_h1 || $stable(line_rd)),
                   "sum stage lost its item under stall")

endmodule

`default_nettype wire

@@ test/mipmap_box_downsampler_core_tb.sv @@
// Self-checking testbench for the 2x2 box-filter mipmap downsampler core.
module mipmap_box_downsampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  localparam int CLK_HALF      = 6;     // 12 ns period
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 6;     // pad after the owed pixels drain
  localparam int RANDOM_ITEMS  = 233;
  localparam int HOLD_CYCLES   = 300;   // one long receiver hold-off
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transfer before giving up
  localparam int REPORT_MAX    = 10;

  // Predicts the reduced image from the accepted source pixels and keeps the
  // reduced pixels still owed by the block, oldest first.
  class box_average_book;
    int unsigned width, height;
    int unsigned col, row;
    int unsigned pair_line [LINE_DEPTH][NCHAN];
    int unsigned held [NCHAN];
    mip_pixel_t  owed_mips [$];
    int unsigned taken, checked, mismatches;

    function new();
      width = 1;
      height = 1;
      col = 0;
      row = 0;
      taken = 0;
      checked = 0;
      mismatches = 0;
      for (int k = 0; k < NCHAN; k++) held[k] = 0;
    endfunction

    // Size write: mask to the register width, clamp, restart the frame.
    function void set_size(logic idx, int unsigned value);
      int unsigned v;
      v = value & 32'h1FFF;
      if (v == 0) v = 1;
      if (idx == REG_SOURCE_WIDTH) begin
        width = (v > MAX_WIDTH) ? MAX_WIDTH : v;
      end else begin
        height = (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
      end
      col = 0;
      row = 0;
    endfunction

    function void take_source(src_pixel_t p);
      int unsigned ch [NCHAN];
      int unsigned pair [NCHAN];
      int unsigned sum [NCHAN];
      int unsigned ow, oh, x, y;
      bit have_pair, emit;
      mip_pixel_t m;
      ch[0] = p.red;
      ch[1] = p.green;
      ch[2] = p.blue;
      ch[3] = p.alpha;
      taken++;
      ow = (width / 2 != 0) ? width / 2 : 1;
      oh = (height / 2 != 0) ? height / 2 : 1;
      if (col >= width) col = 0;
      if (row >= height) row = 0;
      have_pair = 1'b0;
      emit = 1'b0;
      // Form the horizontal pair; a one-pixel-wide image counts its column twice.
      if (width == 1) begin
        for (int k = 0; k < NCHAN; k++) pair[k] = 2 * ch[k];
        have_pair = 1'b1;
      end else if (col % 2 == 0) begin
        held = ch;
      end else begin
        for (int k = 0; k < NCHAN; k++) pair[k] = held[k] + ch[k];
        have_pair = 1'b1;
      end
      x = col / 2;
      y = row / 2;
      if (have_pair) begin
        if (height == 1) begin
          for (int k = 0; k < NCHAN; k++) sum[k] = 2 * pair[k];
          emit = 1'b1;
        end else if (row % 2 == 0) begin
          if (y < oh) pair_line[x] = pair;
        end else begin
          for (int k = 0; k < NCHAN; k++) sum[k] = pair_line[x][k] + pair[k];
          emit = 1'b1;
        end
      end
      if (emit) begin
        m.out_red       = 8'(sum[0] >> 2);
        m.out_green     = 8'(sum[1] >> 2);
        m.out_blue      = 8'(sum[2] >> 2);
        m.out_alpha     = 8'(sum[3] >> 2);
        m.last_of_image = (x == ow - 1) && (y == oh - 1);
        owed_mips = {owed_mips, m};
      end
      col++;
      if (col >= width) begin
        col = 0;
        row++;
        if (row >= height) row = 0;
      end
    endfunction

    function void check_mip(mip_pixel_t got);
      mip_pixel_t want;
      if (owed_mips.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: reduced pixel with none owed: r=%h g=%h b=%h a=%h last=%b",
                   $realtime, got.out_red, got.out_green, got.out_blue, got.out_alpha,
                   got.last_of_image);
        return;
      end
      want = owed_mips.pop_front();
      checked++;
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
          got.last_of_image !== want.last_of_image) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: reduced pixel %0d: expected r=%h g=%h b=%h a=%h last=%b, got r=%h g=%h b=%h a=%h last=%b",
                   $realtime, checked, want.out_red, want.out_green, want.out_blue,
                   want.out_alpha, want.last_of_image, got.out_red, got.out_green,
                   got.out_blue, got.out_alpha, got.last_of_image);
      end
    endfunction
  endclass

  // Every input starts at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              src_valid = 1'b0;
  logic              src_stall;
  src_pixel_t        src = '0;
  logic              mip_valid;
  logic              mip_stall = 1'b0;
  mip_pixel_t        mip;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  box_average_book book;
  bit              tx_calm = 1'b0;   // sender offers back to back when set
  bit              hold_ask = 1'b0;  // ask the receiver for its long hold-off
  int unsigned     reg_writes = 0;
  int unsigned     quiet_cycles = 0;

  mipmap_box_downsampler_core u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .mip_valid (mip_valid),
    .mip_stall (mip_stall),
    .mip       (mip),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off that
  // lets the block fill up and push back on the source side.
  int  stall_left = 0;
  int  mood_left = 0;
  bit  rx_calm = 1'b0;
  bit  hold_done = 1'b0;
  int  rx_pick;

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_ask && !hold_done) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (mood_left == 0) begin
        mood_left = $urandom_range(300, 50);
        rx_calm = ($urandom_range(3, 0) == 0);
      end
      mood_left--;
      if (stall_left > 0) begin
        stall_left--;
        mip_stall <= 1'b1;
      end else if (rx_calm) begin
        mip_stall <= 1'b0;
      end else begin
        rx_pick = $urandom_range(99, 0);
        if (rx_pick < 65) begin
          mip_stall <= 1'b0;
        end else if (rx_pick < 93) begin
          stall_left = $urandom_range(2, 0);
          mip_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(40, 10);
          mip_stall <= 1'b1;
        end
      end
    end
  end

  // Check every reduced pixel the moment it is taken.
  always @(posedge clk) begin
    if (!rst && mip_valid && !mip_stall) book.check_mip(mip);
  end

  // Watchdog: give up when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (mip_valid && !mip_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d reduced pixels still owed",
               $realtime, QUIET_LIMIT, book.owed_mips.size());
      $display("mipmap_box_downsampler_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Random pixel, with flat black or white now and then.
  function automatic src_pixel_t rand_pixel();
    src_pixel_t p;
    p = src_pixel_t'($urandom);
    case ($urandom_range(7, 0))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  // Offer one item and hold it until it is taken; valid stays high for the
  // next item unless a gap is drawn.
  task automatic send_pixel(input src_pixel_t p);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src <= p;
    src_valid <= 1'b1;
    do @(posedge clk); while (src_stall);
    book.take_source(p);
  endtask

  task automatic send_pixels(input int n);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  // Drop valid, wait for every owed pixel, then let in-flight items drain.
  task automatic settle();
    src_valid <= 1'b0;
    while (book.owed_mips.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands at the access edge.
  task automatic write_reg(input logic idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    book.set_size(idx, value);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_image(input int unsigned w, input int unsigned h);
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
  endtask

  initial begin
    int unsigned w, h, frame, n, random_sent;
    int          r;

    book = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes are 1x1: each pixel is its own block, counted four times,
    // and each one ends an image.
    send_pixel(src_pixel_t'(32'h00000000));
    send_pixel(src_pixel_t'(32'hFFFFFFFF));
    send_pixel(src_pixel_t'(32'hAA55AA55));
    send_pixel(src_pixel_t'(32'h55AA55AA));
    settle();

    // 4x2: a near-white block truncates down, a near-black one truncates to 0.
    set_image(4, 2);
    send_pixel(src_pixel_t'(32'hFFFFFFFF));
    send_pixel(src_pixel_t'(32'hFFFEFFFF));
    send_pixel(src_pixel_t'(32'h00000100));
    send_pixel(src_pixel_t'(32'h01000001));
    send_pixel(src_pixel_t'(32'hFFFFFEFF));
    send_pixel(src_pixel_t'(32'hFEFFFFFE));
    send_pixel(src_pixel_t'(32'h00010000));
    send_pixel(src_pixel_t'(32'h02010200));
    settle();

    // Odd 3x3: drop the last column and row, one pixel out.
    set_image(3, 3);
    send_pixels(9);
    settle();

    // Zero sizes read as 1.
    set_image(0, 0);
    send_pixels(2);
    settle();

    // Hold off the receiver while the sender streams 2x2 images back to back.
    set_image(2, 2);
    tx_calm = 1'b1;
    hold_ask = 1'b1;
    send_pixels(40);
    settle();
    tx_calm = 1'b0;

    // Random images: mostly whole frames with random pixels, some cut short.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(99, 0);
      if (r < 70) w = $urandom_range(8, 1);
      else if (r < 95) w = $urandom_range(40, 9);
      else w = $urandom_range(128, 41);
      if (w > 40) h = $urandom_range(2, 1);
      else if (w > 8) h = $urandom_range(4, 1);
      else h = $urandom_range(8, 1);
      r = $urandom_range(9, 0);
      if (r == 0) begin
        write_reg(REG_SOURCE_WIDTH, w);
      end else if (r == 1) begin
        write_reg(REG_SOURCE_HEIGHT, h);
      end else if (r == 2 && w == 1) begin
        set_image(0, h);
      end else begin
        set_image(w, h);
      end
      frame = book.width * book.height;
      n = frame * $urandom_range(3, 1);
      if ($urandom_range(6, 0) == 0 && n > 1) n = $urandom_range(n - 1, 1);
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      tx_calm = ($urandom_range(3, 0) == 0);
      send_pixels(n);
      settle();
      random_sent += n;
    end
    tx_calm = 1'b0;

    // Oversize width saturates to the full line store; one row, cut short.
    set_image(8191, 1);
    send_pixels(30);
    settle();

    // Single column down a tall image.
    set_image(0, 64);
    send_pixels(30);
    settle();

    // Exact maximum width on one row, cut short.
    set_image(MAX_WIDTH, 1);
    send_pixels(30);
    settle();

    // Oversize height saturates; run a short stretch of rows.
    set_image(2, 6000);
    send_pixels(24);
    settle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d source pixels and %0d reduced pixels over %0d size writes",
             book.taken, book.checked, reg_writes);
    $display("sizes from 1x1 to 4096 on each side, odd, zero and oversize, with stalls");
    if (book.mismatches == 0 && book.owed_mips.size() == 0) begin
      $display("mipmap_box_downsampler_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d reduced pixels never seen",
               book.mismatches, book.owed_mips.size());
      $display("mipmap_box_downsampler_core regression: fail");
    end
    $finish;
  end

endmodule
